/* src/text_console_writer_defines.svh */
// Assertion macros shared by the console RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst, prop, msg)
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* src/tcw_pkg.sv */
// Package for the text console writer: payload types, request codes and defaults.
// Depends on nothing.
package tcw_pkg;

  localparam int WIDTH_DEF  = 80;
  localparam int HEIGHT_DEF = 25;

  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_IDX_W = 11;
  localparam int CUR_OUT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;
  localparam int                TAB_STEP    = 4;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    cell_value;
    logic [CUR_OUT_W-1:0] cursor_col;
  } rsp_t;

endpackage

/* src/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module tcw_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tcw_cell_addr.sv */
// Turns a row-major screen index into a physical RAM address over three stages.
// Depends on tcw_pkg for the index width.
module tcw_cell_addr #(
  parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
  parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [tcw_pkg::CELL_IDX_W-1:0]      cell_index,
  input  logic [$clog2(HEIGHT)-1:0]           top,
  output logic                                done,
  output logic [$clog2(HEIGHT)-1:0]           phys,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]     addr
);

  localparam int IW    = tcw_pkg::CELL_IDX_W;
  localparam int RW    = $clog2(HEIGHT);
  localparam int CLW   = $clog2(WIDTH);
  localparam int AW    = $clog2(WIDTH * HEIGHT);
  // Reciprocal of WIDTH, exact for every IW-bit dividend.
  localparam int SH    = IW + $clog2(WIDTH);
  localparam int RECIP = ((1 << SH) + WIDTH - 1) / WIDTH;
  localparam int PW    = SH + IW;

  logic          s1, s2, s3;
  logic [PW-1:0] prod;
  logic [IW-1:0] idx1;
  logic [RW-1:0] row;
  logic [RW:0]   psum;
  logic [RW-1:0] phys_d;
  logic [CLW-1:0] col_d;
  logic [CLW-1:0] col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
      s3 <= 1'b0;
    end else begin
      s1 <= start;
      s2 <= s1;
      s3 <= s2;
    end
  end

  always_comb begin
    row    = RW'(prod >> SH);
    col_d  = CLW'(32'(idx1) - 32'(row) * WIDTH);
    psum   = (RW+1)'(top) + (RW+1)'(row);
    phys_d = (psum >= (RW+1)'(HEIGHT)) ? RW'(psum - (RW+1)'(HEIGHT)) : RW'(psum);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PW'(cell_index) * PW'(RECIP);
      idx1 <= cell_index;
    end
    if (s1) begin
      phys <= phys_d;
      col  <= col_d;
    end
    if (s2) begin
      addr <= AW'(32'(phys) * WIDTH + 32'(col));
    end
  end

  assign done = s3;

endmodule

/* src/text_console_writer.sv */
// Top level of the text console writer: request sequencer, row bookkeeping and screen RAM.
// Depends on tcw_pkg, tcw_ram, tcw_cell_addr and text_console_writer_defines.svh.
//
//   channel | direction | payload        | transaction when
//   req     | in        | tcw_pkg::req_t | req_valid && req_ready
//   rsp     | out       | tcw_pkg::rsp_t | rsp_valid && rsp_ready
//
// One request at a time; the next request is taken while the previous response waits.
// Newline, tab, clear, ignored codes and out-of-range reads pass S_EXEC and S_DONE;
// a read also passes S_ADDR and S_READ, a printable character S_PUT, sweeping a stale row:
// a scrolled or cleared row is only marked blank, and the first write sweeps it in RAM.
// Reset needs no clearing pass: per-row blank flags make every row read as zero.
// A response held by rsp_ready stalls completion of the following request only.
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
  parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tcw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tcw_pkg::rsp_t rsp
);

  localparam int CW    = $clog2(WIDTH + 1);
  localparam int RW    = $clog2(HEIGHT);
  localparam int CLW   = $clog2(WIDTH);
  localparam int AW    = $clog2(WIDTH * HEIGHT);
  localparam int CELLS = WIDTH * HEIGHT;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_PUT  = 6'b000100,
    S_ADDR = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t        state;
  tcw_pkg::req_t item;
  logic [CW-1:0] cursor;
  logic [RW-1:0] top;
  logic [HEIGHT-1:0] row_ok;
  logic [tcw_pkg::CHAR_W-1:0] value;

  logic [RW-1:0]  wr_row;
  logic [AW-1:0]  wr_base;
  logic [CLW-1:0] wr_col;
  logic           wr_rv;
  logic [CLW-1:0] cnt;
  logic           rd_rv;

  logic [RW-1:0]  top_inc;
  logic [RW-1:0]  bottom;
  logic [CW:0]    tab_sum;
  logic [CW:0]    tab_al;
  logic [CW-1:0]  tab_cur;
  logic           printable;
  logic           in_range;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [tcw_pkg::CHAR_W-1:0] mem_wdata;
  logic [tcw_pkg::CHAR_W-1:0] mem_rdata;

  logic           au_start;
  logic           au_done;
  logic [RW-1:0]  au_phys;
  logic [AW-1:0]  au_addr;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    top_inc   = (top == RW'(HEIGHT - 1)) ? '0 : RW'(top + 1'b1);
    bottom    = (top == '0) ? RW'(HEIGHT - 1) : RW'(top - 1'b1);
    tab_sum   = (CW+1)'(cursor) + (CW+1)'(tcw_pkg::TAB_STEP);
    tab_al    = tab_sum & ~(CW+1)'(tcw_pkg::TAB_STEP - 1);
    tab_cur   = (tab_al > (CW+1)'(WIDTH)) ? CW'(WIDTH) : CW'(tab_al);
    printable = (item.char_code >= tcw_pkg::CH_PRINT_LO) &&
                (item.char_code <= tcw_pkg::CH_PRINT_HI);
    in_range  = 32'(item.cell_index) < CELLS;
    au_start  = (state == S_EXEC) && (item.mode == tcw_pkg::MODE_READ) && in_range;
  end

  // Into a row already swept the character goes straight in; a stale row is swept
  // with zeros and the character lands on its pass.
  always_comb begin
    mem_we    = (state == S_PUT);
    mem_waddr = wr_rv ? AW'(wr_base + AW'(wr_col)) : AW'(wr_base + AW'(cnt));
    mem_wdata = (wr_rv || cnt == wr_col) ? item.char_code : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      top       <= '0;
      row_ok    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          value <= '0;
          case (item.mode)
            tcw_pkg::MODE_PUT: begin
              if (item.char_code == tcw_pkg::CH_NEWLINE) begin
                cursor      <= '0;
                top         <= top_inc;
                row_ok[top] <= 1'b0;
                state       <= S_DONE;
              end else if (item.char_code == tcw_pkg::CH_TAB) begin
                cursor <= tab_cur;
                state  <= S_DONE;
              end else if (printable) begin
                cnt   <= '0;
                state <= S_PUT;
                if (cursor < CW'(WIDTH)) begin
                  wr_row  <= bottom;
                  wr_base <= AW'(32'(bottom) * WIDTH);
                  wr_col  <= CLW'(cursor);
                  wr_rv   <= row_ok[bottom];
                  cursor  <= CW'(cursor + 1'b1);
                end else begin
                  // Wrap: scroll first, the old top row becomes the blank bottom row.
                  top         <= top_inc;
                  row_ok[top] <= 1'b0;
                  wr_row      <= top;
                  wr_base     <= AW'(32'(top) * WIDTH);
                  wr_col      <= '0;
                  wr_rv       <= 1'b0;
                  cursor      <= CW'(1);
                end
              end else begin
                state <= S_DONE;
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              cursor <= '0;
              top    <= '0;
              row_ok <= '0;
              state  <= S_DONE;
            end
            tcw_pkg::MODE_READ: begin
              state <= in_range ? S_ADDR : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_PUT: begin
          if (wr_rv) begin
            state <= S_DONE;
          end else begin
            cnt <= CLW'(cnt + 1'b1);
            if (cnt == CLW'(WIDTH - 1)) begin
              row_ok[wr_row] <= 1'b1;
              state          <= S_DONE;
            end
          end
        end
        S_ADDR: begin
          if (au_done) begin
            rd_rv <= row_ok[au_phys];
            state <= S_READ;
          end
        end
        S_READ: begin
          value <= rd_rv ? mem_rdata : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.cell_value <= value;
            rsp.cursor_col <= tcw_pkg::CUR_OUT_W'(cursor);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tcw_cell_addr #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_cell_addr (
    .clk        (clk),
    .rst        (rst),
    .start      (au_start),
    .cell_index (item.cell_index),
    .top        (top),
    .done       (au_done),
    .phys       (au_phys),
    .addr       (au_addr)
  );

  tcw_ram #(
    .DATA_W (tcw_pkg::CHAR_W),
    .DEPTH  (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (au_addr),
    .rdata (mem_rdata)
  );

  `TCW_ASSERT(a_cursor_range, clk, rst, cursor <= CW'(WIDTH), "cursor beyond the last column")
  `TCW_ASSERT(a_top_range, clk, rst, top <= RW'(HEIGHT - 1), "top row pointer out of range")
  `TCW_ASSERT_IMP(a_one_at_a_time, clk, rst, req_valid && req_ready, ##1 !req_ready, "second request taken while busy")
  `TCW_ASSERT_IMP(a_write_range, clk, rst, mem_we, 32'(mem_waddr) < CELLS, "screen write outside the RAM")
  `TCW_ASSERT_IMP(a_sweep_marks, clk, rst, state == S_PUT && !wr_rv && cnt == CLW'(WIDTH - 1), ##1 row_ok[wr_row], "swept row not marked blank-free")

endmodule

/* bench/tb_text_console_writer.sv */
// Self-checking testbench for text_console_writer: directed and random request streams,
// each response checked against a behavioural model of the scrolling console.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = tcw_pkg::WIDTH_DEF;
  localparam int ROWS  = tcw_pkg::HEIGHT_DEF;
  localparam int CELLS = COLS * ROWS;
  localparam logic [tcw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  tcw_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  tcw_pkg::rsp_t rsp;

  // Behavioural copy of the console.
  logic [7:0] screen [CELLS];
  int cursor = 0;
  int top_row = 0;

  tcw_pkg::rsp_t awaited_rsp_q[$];
  int   errors = 0;
  int   items_sent = 0;
  bit   no_idle = 1'b0;

  text_console_writer #(.WIDTH(COLS), .HEIGHT(ROWS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= no_idle || ($urandom_range(0, 99) >= 28);
  end

  function automatic int bottom_row();
    return (top_row + ROWS - 1) % ROWS;
  endfunction

  function automatic void scroll_screen();
    top_row = (top_row + 1) % ROWS;
    for (int c = 0; c < COLS; c++) begin
      screen[bottom_row() * COLS + c] = 8'h00;
    end
  endfunction

  function automatic tcw_pkg::rsp_t console_step(tcw_pkg::req_t r);
    tcw_pkg::rsp_t o;
    int   idx;
    o   = '0;
    idx = r.cell_index;
    case (r.mode)
      tcw_pkg::MODE_PUT: begin
        if (r.char_code == tcw_pkg::CH_NEWLINE) begin
          cursor = 0;
          scroll_screen();
        end else if (r.char_code == tcw_pkg::CH_TAB) begin
          cursor = (cursor + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
          if (cursor > COLS) cursor = COLS;
        end else if (r.char_code >= tcw_pkg::CH_PRINT_LO &&
                     r.char_code <= tcw_pkg::CH_PRINT_HI) begin
          // A printable code at the end of the row scrolls first and lands in column 0.
          if (cursor >= COLS) begin
            scroll_screen();
            cursor = 0;
          end
          screen[bottom_row() * COLS + cursor] = r.char_code;
          cursor++;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        foreach (screen[i]) screen[i] = 8'h00;
        cursor  = 0;
        top_row = 0;
      end
      tcw_pkg::MODE_READ: begin
        if (idx < CELLS) begin
          o.cell_value = screen[((top_row + idx / COLS) % ROWS) * COLS + idx % COLS];
        end
      end
      default: ;
    endcase
    o.cursor_col = tcw_pkg::CUR_OUT_W'(cursor);
    return o;
  endfunction

  function automatic tcw_pkg::req_t make_req(logic [tcw_pkg::MODE_W-1:0] m,
                                             logic [tcw_pkg::CHAR_W-1:0] c,
                                             logic [tcw_pkg::CELL_IDX_W-1:0] i);
    tcw_pkg::req_t r;
    r.mode       = m;
    r.char_code  = c;
    r.cell_index = i;
    return r;
  endfunction

  function automatic logic [tcw_pkg::CELL_IDX_W-1:0] near_bottom_index();
    return tcw_pkg::CELL_IDX_W'((ROWS - 1 - $urandom_range(0, 2)) * COLS +
                                $urandom_range(0, COLS - 1));
  endfunction

  // Drives one request and books its predicted response once the transaction completes.
  task automatic send_req(input tcw_pkg::req_t item);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 28) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    awaited_rsp_q.push_back(console_step(item));
    items_sent++;
  endtask

  task automatic send_put(input logic [tcw_pkg::CHAR_W-1:0] c);
    send_req(make_req(tcw_pkg::MODE_PUT, c, tcw_pkg::CELL_IDX_W'($urandom_range(0, 2047))));
  endtask

  task automatic send_read(input logic [tcw_pkg::CELL_IDX_W-1:0] i);
    send_req(make_req(tcw_pkg::MODE_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)), i));
  endtask

  always @(posedge clk) begin : rsp_check
    tcw_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp_q.size() == 0) begin
        $display("%0t: response with none pending: cell_value %0d cursor_col %0d",
                 $time, rsp.cell_value, rsp.cursor_col);
        errors++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp.cell_value !== want.cell_value) begin
          $display("%0t: cell_value expected %0d actual %0d",
                   $time, want.cell_value, rsp.cell_value);
          errors++;
        end
        if (rsp.cursor_col !== want.cursor_col) begin
          $display("%0t: cursor_col expected %0d actual %0d",
                   $time, want.cursor_col, rsp.cursor_col);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_reads();
    send_read(11'd0);
    send_read(tcw_pkg::CELL_IDX_W'(CELLS - 1));
    send_read(tcw_pkg::CELL_IDX_W'(CELLS));
    send_req(make_req(tcw_pkg::MODE_READ, 8'hFF, 11'h7FF));
    send_req(make_req(MODE_UNUSED, 8'hFF, 11'h7FF));
    send_req(make_req(MODE_UNUSED, 8'h41, 11'h000));
  endtask

  task automatic test_characters();
    send_put(tcw_pkg::CH_PRINT_LO);
    send_put(8'h41);
    send_put(tcw_pkg::CH_PRINT_HI);
    // Codes outside the handled set must leave screen and cursor untouched.
    send_put(8'd31);
    send_put(8'd127);
    send_put(8'd128);
    send_put(8'hFF);
    send_put(8'h00);
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 1) * COLS));
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 1) * COLS + 1));
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 1) * COLS + 2));
  endtask

  task automatic test_tab_and_wrap();
    send_put(tcw_pkg::CH_NEWLINE);
    repeat (COLS / tcw_pkg::TAB_STEP - 1) send_put(tcw_pkg::CH_TAB);
    send_put(8'h78);
    send_put(tcw_pkg::CH_TAB);
    send_put(tcw_pkg::CH_TAB);
    send_put(8'h79);
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 1) * COLS));
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 2) * COLS + COLS - tcw_pkg::TAB_STEP));
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 3) * COLS + 1));
  endtask

  task automatic test_clear();
    send_req(make_req(tcw_pkg::MODE_CLEAR, 8'hFF, 11'h7FF));
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 1) * COLS));
    send_put(8'h7A);
    send_read(tcw_pkg::CELL_IDX_W'((ROWS - 1) * COLS));
  endtask

  // A line of text with tabs and the odd read; long lines run past the end of the row.
  task automatic send_text_line(input int len);
    int pick;
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) send_put(tcw_pkg::CH_TAB);
      else if (pick == 2) send_read(near_bottom_index());
      else send_put(tcw_pkg::CHAR_W'($urandom_range(32, 126)));
    end
    if ($urandom_range(0, 9) < 7) send_put(tcw_pkg::CH_NEWLINE);
  endtask

  task automatic send_random_stretch();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      send_text_line($urandom_range(0, 3) == 0 ? $urandom_range(60, 100) : $urandom_range(0, 30));
    end else if (pick < 8) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) == 0) send_read(near_bottom_index());
        else send_read(tcw_pkg::CELL_IDX_W'($urandom_range(0, 2047)));
      end
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 3)) begin
        send_req(make_req(tcw_pkg::MODE_W'($urandom_range(0, 3)),
                          tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                          tcw_pkg::CELL_IDX_W'($urandom_range(0, 2047))));
      end
    end else if ($urandom_range(0, 7) == 0) begin
      send_req(make_req(tcw_pkg::MODE_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                        tcw_pkg::CELL_IDX_W'($urandom_range(0, 2047))));
    end else begin
      repeat ($urandom_range(1, 3)) send_put(tcw_pkg::CH_NEWLINE);
    end
  endtask

  task automatic test_back_to_back();
    int stop_at;
    stop_at = items_sent + 150;
    no_idle = 1'b1;
    while (items_sent < stop_at) send_random_stretch();
    no_idle = 1'b0;
  endtask

  task automatic test_random_text();
    int stop_at;
    stop_at = items_sent + RANDOM_ITEMS - 150;
    while (items_sent < stop_at) send_random_stretch();
  endtask

  initial begin
    foreach (screen[i]) screen[i] = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_reads();
    test_characters();
    test_tab_and_wrap();
    test_clear();
    test_back_to_back();
    test_random_text();
    req_valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (2 * COLS) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // The slowest legal run is well under a tenth of this.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
